// File: rtl/core/cdhi_pkg.sv
// Shared types, codes, constants and tables of the disc controller host interface.
`timescale 1ns / 1ps

package cdhi_pkg;

	localparam int SECTOR_WORDS = 588;
	localparam logic [11:0] DATA_END = 12'h818;
	localparam logic [11:0] OFS_FULL = 12'h00C;
	localparam logic [11:0] OFS_DATA = 12'h018;
	localparam logic [19:0] ADDR_BIAS = 20'd150;
	localparam logic [19:0] ADDR_MAX = 20'd449849;

	// Timer delays in clock cycles.
	localparam logic [21:0] DLY_ACK = 22'd10000;
	localparam logic [21:0] DLY_INIT = 22'd80000;
	localparam logic [21:0] DLY_INIT2 = 22'd100000;
	localparam logic [21:0] DLY_SINGLE = 22'd451584;
	localparam logic [21:0] DLY_DOUBLE = 22'd225792;
	localparam logic [21:0] DLY_READN_SG = 22'd461584;
	localparam logic [21:0] DLY_READN_DB = 22'd235792;
	localparam logic [21:0] DLY_PAUSE_IDLE = 22'd20000;
	localparam logic [21:0] DLY_PAUSE_BUSY = 22'd2267920;
	localparam logic [21:0] DLY_SEEKL = 22'd90000;
	localparam logic [21:0] DLY_GETID = 22'd40000;
	localparam logic [21:0] DLY_TOC = 22'd30000;

	localparam logic [1:0] IRQ_ONE = 2'd1;
	localparam logic [1:0] IRQ_TWO = 2'd2;
	localparam logic [1:0] IRQ_THREE = 2'd3;

	// Input operation codes.
	localparam logic [2:0] OP_PREAD = 3'd0;
	localparam logic [2:0] OP_PWRITE = 3'd1;
	localparam logic [2:0] OP_EVENT = 3'd2;
	localparam logic [2:0] OP_LOAD = 3'd3;
	localparam logic [2:0] OP_DREAD = 3'd4;

	// Port offsets and banks.
	localparam logic [2:0] PORT_INDEX = 3'd0;
	localparam logic [2:0] PORT_ONE = 3'd1;
	localparam logic [2:0] PORT_TWO = 3'd2;
	localparam logic [2:0] PORT_THREE = 3'd3;
	localparam logic [1:0] BANK_ZERO = 2'd0;
	localparam logic [1:0] BANK_ONE = 2'd1;
	localparam logic [1:0] BANK_TWO = 2'd2;

	// Drive commands.
	localparam logic [7:0] CMD_GETSTAT = 8'h01;
	localparam logic [7:0] CMD_SETLOC = 8'h02;
	localparam logic [7:0] CMD_READN = 8'h06;
	localparam logic [7:0] CMD_PAUSE = 8'h09;
	localparam logic [7:0] CMD_INIT = 8'h0A;
	localparam logic [7:0] CMD_DEMUTE = 8'h0C;
	localparam logic [7:0] CMD_SETMODE = 8'h0E;
	localparam logic [7:0] CMD_GETTN = 8'h13;
	localparam logic [7:0] CMD_GETTD = 8'h14;
	localparam logic [7:0] CMD_SEEKL = 8'h15;
	localparam logic [7:0] CMD_TEST = 8'h19;
	localparam logic [7:0] CMD_GETID = 8'h1A;
	localparam logic [7:0] CMD_READTOC = 8'h1E;
	localparam logic [7:0] TEST_DATE = 8'h20;

	typedef enum logic [2:0] {
		K_BYTE   = 3'd0,
		K_WORD   = 3'd1,
		K_SCHED  = 3'd2,
		K_CANCEL = 3'd3,
		K_SECTOR = 3'd4,
		K_INT    = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LATCH,
		ACT_PREAD,
		ACT_PWRITE,
		ACT_DELIVER,
		ACT_PREP,
		ACT_SECTOR,
		ACT_LOAD,
		ACT_DREAD,
		ACT_LONE
	} act_t;

	typedef enum logic [1:0] {
		PS_STATUS,
		PS_MODE,
		PS_CONST
	} psrc_t;

	typedef enum logic [2:0] {
		PD_NONE,
		PD_MIN,
		PD_SEC,
		PD_FRM,
		PD_MODE
	} pdst_t;

	typedef enum logic [2:0] {
		SO_NONE,
		SO_CLR_SHELL,
		SO_READ,
		SO_STOP,
		SO_MOTOR,
		SO_SEEK,
		SO_MOTOR_READ
	} stop_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		act_t        act;
		logic        push;
		psrc_t       psrc;
		logic [7:0]  pconst;
		logic        pop;
		pdst_t       pdst;
		stop_t       st_op;
		logic        mode_init;
		logic        resp_clear;
		logic        sched;
		logic [1:0]  sirq;
		logic [21:0] sdelay;
		logic        cancel;
		logic        err;
		logic        out_adv;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] port;
		logic [7:0] wbyte;
		logic [1:0] irq;
		logic [1:0] bank;
		logic       prm_empty;
		logic [7:0] prm_head;
		logic       speed;
		logic       play_read;
		logic [1:0] res_cnt;
		logic       err;
		logic       out_last;
	} dp_stat_t;

	function automatic logic [7:0] ident_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h02;
			3'd1: b = 8'h00;
			3'd2: b = 8'h20;
			3'd3: b = 8'h00;
			3'd4: b = 8'h4D;
			3'd5: b = 8'h41;
			3'd6: b = 8'h52;
			default: b = 8'h49;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] date_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h96;
			2'd1: b = 8'h09;
			2'd2: b = 8'h12;
			default: b = 8'hC2;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] bcd_fix(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		if (v[3:0] == 4'd10) begin
			r = (v + 8'h10) & 8'hF0;
		end
		return r;
	endfunction

	function automatic logic [7:0] bcd_val(input logic [7:0] b);
		return ({4'd0, b[7:4]} << 3) + ({4'd0, b[7:4]} << 1) + {4'd0, b[3:0]};
	endfunction

endpackage

// File: rtl/core/cdrom_controller_host_interface_unit.sv
// Top level of the disc controller host interface: controller and datapath.
//
//  channel | direction | handshake            | payload
//  input   | in        | in_valid / in_ready  | operation, port, write_byte, event_irq,
//          |           |                      | load_word, load_index
//  output  | out       | out_valid / out_ready| kind, read_byte, data_word, sched_irq,
//          |           |                      | sched_delay, sector_address, last, error
//
// One transaction at a time: accept, 1 to 9 command steps (GetID is the longest with
// one response FIFO write per step), a finish state, then one result per cycle while
// out_ready is high. Parameter and response FIFO heads are registered and follow
// their pointers in the cycle after they move. Reset clears all control state at once;
// no clearing pass runs over the stores. in_ready is low while a transaction is
// processed or its results are stalled.
`timescale 1ns / 1ps

module cdrom_controller_host_interface_unit import cdhi_pkg::*; #(
	parameter int PARAM_DEPTH = 16,
	parameter int RESPONSE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         operation,
	input  logic [2:0]         port,
	input  logic [7:0]         write_byte,
	input  logic [1:0]         event_irq,
	input  logic [31:0]        load_word,
	input  logic [9:0]         load_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         kind,
	output logic [7:0]         read_byte,
	output logic [31:0]        data_word,
	output logic [1:0]         sched_irq,
	output logic [21:0]        sched_delay,
	output logic signed [19:0] sector_address,
	output logic               last,
	output logic               error
);

	dp_cmd_t cmd;
	dp_stat_t stat;

	cdhi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cdhi_dp #(
		.PARAM_DEPTH   (PARAM_DEPTH),
		.RESPONSE_DEPTH(RESPONSE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.operation     (operation),
		.port          (port),
		.write_byte    (write_byte),
		.event_irq     (event_irq),
		.load_word     (load_word),
		.load_index    (load_index),
		.kind          (kind),
		.read_byte     (read_byte),
		.data_word     (data_word),
		.sched_irq     (sched_irq),
		.sched_delay   (sched_delay),
		.sector_address(sector_address),
		.last          (last),
		.error         (error)
	);

endmodule

// File: rtl/core/cdhi_ctrl.sv
// Controller state machine: sequences input operations and drive command steps.
`timescale 1ns / 1ps

module cdhi_ctrl import cdhi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t st_q, st_d;
	logic [3:0] step_q, step_d;
	logic done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			step_q <= 4'd0;
		end else begin
			st_q <= st_d;
			step_q <= step_d;
		end
	end

	always_comb begin
		cmd = '0;
		st_d = st_q;
		step_d = step_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		done = 1'b1;
		case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.act = ACT_LATCH;
					st_d = ST_RUN;
					step_d = 4'd0;
				end
			end
			ST_RUN: begin
				step_d = step_q + 4'd1;
				case (stat.op)
					OP_PREAD: cmd.act = ACT_PREAD;
					OP_PWRITE: begin
						if (stat.port == PORT_ONE && stat.bank == BANK_ZERO) begin
							case (stat.wbyte)
								CMD_GETSTAT: begin
									cmd.push = 1'b1;
									cmd.psrc = PS_STATUS;
									cmd.st_op = SO_CLR_SHELL;
									cmd.sched = 1'b1;
									cmd.sirq = IRQ_THREE;
									cmd.sdelay = DLY_ACK;
								end
								CMD_SETLOC: begin
									case (step_q)
										4'd0: begin
											cmd.push = 1'b1;
											cmd.psrc = PS_STATUS;
											cmd.pop = 1'b1;
											cmd.pdst = PD_MIN;
											done = 1'b0;
										end
										4'd2: begin
											cmd.pop = 1'b1;
											cmd.pdst = PD_SEC;
											done = 1'b0;
										end
										4'd4: begin
											cmd.pop = 1'b1;
											cmd.pdst = PD_FRM;
											cmd.sched = 1'b1;
											cmd.sirq = IRQ_THREE;
											cmd.sdelay = DLY_ACK;
										end
										// Odd steps let the parameter head refill.
										default: done = 1'b0;
									endcase
								end
								CMD_READN: begin
									cmd.sched = 1'b1;
									if (step_q == 4'd0) begin
										cmd.push = 1'b1;
										cmd.psrc = PS_STATUS;
										cmd.st_op = SO_READ;
										cmd.sirq = IRQ_THREE;
										cmd.sdelay = DLY_ACK;
										done = 1'b0;
									end else begin
										cmd.sirq = IRQ_ONE;
										cmd.sdelay = stat.speed ? DLY_READN_DB : DLY_READN_SG;
									end
								end
								CMD_PAUSE: begin
									case (step_q)
										4'd0: begin
											cmd.cancel = 1'b1;
											cmd.resp_clear = 1'b1;
											done = 1'b0;
										end
										4'd1: begin
											cmd.push = 1'b1;
											cmd.psrc = PS_STATUS;
											cmd.sched = 1'b1;
											cmd.sirq = IRQ_THREE;
											cmd.sdelay = DLY_ACK;
											done = 1'b0;
										end
										4'd2: begin
											cmd.sched = 1'b1;
											cmd.sirq = IRQ_TWO;
											cmd.sdelay = stat.play_read ? DLY_PAUSE_BUSY
												: DLY_PAUSE_IDLE;
											cmd.st_op = SO_STOP;
											done = 1'b0;
										end
										default: begin
											cmd.push = 1'b1;
											cmd.psrc = PS_STATUS;
										end
									endcase
								end
								CMD_INIT: begin
									cmd.push = 1'b1;
									cmd.psrc = PS_MODE;
									cmd.sched = 1'b1;
									if (step_q == 4'd0) begin
										cmd.sirq = IRQ_THREE;
										cmd.sdelay = DLY_INIT;
										cmd.st_op = SO_MOTOR;
										cmd.mode_init = 1'b1;
										done = 1'b0;
									end else begin
										cmd.sirq = IRQ_TWO;
										cmd.sdelay = DLY_INIT2;
									end
								end
								CMD_DEMUTE: begin
									cmd.push = 1'b1;
									cmd.psrc = PS_STATUS;
									cmd.sched = 1'b1;
									cmd.sirq = IRQ_THREE;
									cmd.sdelay = DLY_ACK;
								end
								CMD_SETMODE: begin
									cmd.push = 1'b1;
									cmd.psrc = PS_STATUS;
									cmd.pop = 1'b1;
									cmd.pdst = PD_MODE;
									cmd.sched = 1'b1;
									cmd.sirq = IRQ_THREE;
									cmd.sdelay = DLY_ACK;
								end
								CMD_GETTN, CMD_GETTD: begin
									cmd.push = 1'b1;
									if (step_q == 4'd0) begin
										cmd.psrc = PS_STATUS;
										cmd.pop = (stat.wbyte == CMD_GETTD);
										cmd.pdst = PD_NONE;
										cmd.sched = 1'b1;
										cmd.sirq = IRQ_THREE;
										cmd.sdelay = DLY_ACK;
									end else begin
										cmd.psrc = PS_CONST;
										cmd.pconst = (stat.wbyte == CMD_GETTN) ? 8'h01 : 8'h00;
									end
									done = (step_q == 4'd2);
								end
								CMD_SEEKL: begin
									cmd.push = 1'b1;
									cmd.psrc = PS_STATUS;
									cmd.sched = 1'b1;
									if (step_q == 4'd0) begin
										cmd.sirq = IRQ_THREE;
										cmd.sdelay = DLY_ACK;
										cmd.st_op = SO_SEEK;
										done = 1'b0;
									end else begin
										cmd.sirq = IRQ_TWO;
										cmd.sdelay = DLY_SEEKL;
									end
								end
								CMD_TEST: begin
									if (step_q == 4'd0) begin
										cmd.pop = 1'b1;
										cmd.pdst = PD_NONE;
										if (!stat.prm_empty && stat.prm_head == TEST_DATE) begin
											cmd.push = 1'b1;
											cmd.psrc = PS_CONST;
											cmd.pconst = date_byte(2'd0);
											cmd.sched = 1'b1;
											cmd.sirq = IRQ_THREE;
											cmd.sdelay = DLY_ACK;
											done = 1'b0;
										end else begin
											cmd.err = 1'b1;
										end
									end else begin
										cmd.push = 1'b1;
										cmd.psrc = PS_CONST;
										cmd.pconst = date_byte(step_q[1:0]);
										done = (step_q == 4'd3);
									end
								end
								CMD_GETID: begin
									cmd.push = 1'b1;
									if (step_q == 4'd0) begin
										cmd.psrc = PS_STATUS;
										cmd.sched = 1'b1;
										cmd.sirq = IRQ_THREE;
										cmd.sdelay = DLY_ACK;
									end else begin
										cmd.psrc = PS_CONST;
										cmd.pconst = ident_byte(3'(step_q - 4'd1));
									end
									if (step_q == 4'd8) begin
										cmd.sched = 1'b1;
										cmd.sirq = IRQ_TWO;
										cmd.sdelay = DLY_GETID;
									end
									done = (step_q == 4'd8);
								end
								CMD_READTOC: begin
									case (step_q)
										4'd0: begin
											cmd.push = 1'b1;
											cmd.psrc = PS_STATUS;
											cmd.st_op = SO_MOTOR_READ;
											done = 1'b0;
										end
										4'd1: begin
											cmd.push = 1'b1;
											cmd.psrc = PS_STATUS;
											cmd.sched = 1'b1;
											cmd.sirq = IRQ_THREE;
											cmd.sdelay = DLY_ACK;
											done = 1'b0;
										end
										default: begin
											cmd.sched = 1'b1;
											cmd.sirq = IRQ_TWO;
											cmd.sdelay = DLY_TOC;
										end
									endcase
								end
								default: cmd.err = 1'b1;
							endcase
						end else begin
							cmd.act = ACT_PWRITE;
						end
					end
					OP_EVENT: begin
						case (step_q)
							4'd0: begin
								cmd.act = ACT_DELIVER;
								if (stat.irq == IRQ_ONE) begin
									cmd.push = 1'b1;
									cmd.psrc = PS_STATUS;
									done = 1'b0;
								end
							end
							4'd1: begin
								cmd.act = ACT_PREP;
								done = 1'b0;
							end
							4'd2: begin
								cmd.act = ACT_SECTOR;
								done = 1'b0;
							end
							default: begin
								cmd.sched = 1'b1;
								cmd.sirq = IRQ_ONE;
								cmd.sdelay = stat.speed ? DLY_DOUBLE : DLY_SINGLE;
							end
						endcase
					end
					OP_LOAD: cmd.act = ACT_LOAD;
					OP_DREAD: cmd.act = ACT_DREAD;
					default: cmd.act = ACT_NONE;
				endcase
				if (done) begin
					st_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.act = ACT_LONE;
				st_d = (stat.res_cnt != 2'd0 || stat.err) ? ST_OUT : ST_IDLE;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.out_adv = 1'b1;
					if (stat.out_last) begin
						st_d = ST_IDLE;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

`ifndef ASSERT_OFF
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n) step_q <= 4'd9)
		else $error("command step counter ran past the longest command");
	a_out_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT) |-> (stat.res_cnt != 2'd0))
		else $error("result phase entered with an empty result buffer");
	a_out_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT && out_ready && stat.out_last) |=> (st_q == ST_IDLE))
		else $error("controller did not return to idle after the last result");
`endif

endmodule

// File: rtl/core/cdhi_dp.sv
// Datapath: drive registers, FIFOs, sector store, address logic and result buffer.
`timescale 1ns / 1ps

module cdhi_dp import cdhi_pkg::*; #(
	parameter int PARAM_DEPTH = 16,
	parameter int RESPONSE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic [2:0]         operation,
	input  logic [2:0]         port,
	input  logic [7:0]         write_byte,
	input  logic [1:0]         event_irq,
	input  logic [31:0]        load_word,
	input  logic [9:0]         load_index,
	output logic [2:0]         kind,
	output logic [7:0]         read_byte,
	output logic [31:0]        data_word,
	output logic [1:0]         sched_irq,
	output logic [21:0]        sched_delay,
	output logic signed [19:0] sector_address,
	output logic               last,
	output logic               error
);

	localparam int PCW = $clog2(PARAM_DEPTH + 1);
	localparam int PPW = $clog2(PARAM_DEPTH);
	localparam int RCW = $clog2(RESPONSE_DEPTH + 1);
	localparam int RPW = $clog2(RESPONSE_DEPTH);

	// Latched transaction.
	logic [2:0] op_q, port_q;
	logic [7:0] wbyte_q;
	logic [1:0] irq_q;
	logic [31:0] lword_q;
	logic [9:0] lidx_q;

	logic [1:0] bank_q;
	logic [7:0] mode_q, status_q, min_q, sec_q, frm_q;
	logic [4:0] ien_q, iflg_q;
	logic [11:0] offset_q;

	logic [7:0] prm_mem [PARAM_DEPTH];
	logic [PPW-1:0] prm_rd_q, prm_wr_q;
	logic [PCW-1:0] prm_cnt_q;
	logic [7:0] prm_head_q;

	logic [7:0] rsp_mem [RESPONSE_DEPTH];
	logic [RPW-1:0] rsp_rd_q, rsp_wr_q;
	logic [RCW-1:0] rsp_cnt_q;
	logic [7:0] rsp_head_q;

	logic [31:0] sec_mem [SECTOR_WORDS];
	logic [31:0] sec_rdata_q;
	logic [9:0] sec_raddr;

	logic [7:0] mv_q, sv_q, fv_q;

	kind_t res_kind_q [3];
	logic [31:0] res_val_q [3];
	logic [1:0] res_irq_q [3];
	logic [1:0] res_cnt_q, res_idx_q;
	logic err_q;

	logic app_en;
	kind_t app_kind;
	logic [31:0] app_val;
	logic [1:0] app_irq;
	logic err_set, prm_empty, prm_full, rsp_full, prm_push, rsp_pop, rsp_push;
	logic [7:0] pop_val, push_val, pread_byte;
	logic [4:0] flg_new;
	logic [19:0] lba_sum, lba_addr;
	logic [7:0] f_inc, f_adv, s_mid, s_adv, m_mid, m_adv;
	logic off_ok;

	assign prm_empty = (prm_cnt_q == '0);
	assign prm_full = (prm_cnt_q == PCW'(PARAM_DEPTH));
	assign rsp_full = (rsp_cnt_q == RCW'(RESPONSE_DEPTH));
	assign off_ok = (offset_q < DATA_END);
	assign flg_new = iflg_q | {3'd0, irq_q};
	assign pop_val = prm_empty ? 8'd0 : prm_head_q;
	assign sec_raddr = (offset_q[11:2] < 10'(SECTOR_WORDS)) ? offset_q[11:2] : 10'd0;

	always_comb begin
		case (cmd.psrc)
			PS_STATUS: push_val = status_q;
			PS_MODE: push_val = mode_q;
			default: push_val = cmd.pconst;
		endcase
	end

	// Sector address from the BCD position, saturated at the top of the disc.
	assign lba_sum = 20'(mv_q * 13'd4500) + 20'(sv_q * 7'd75) + {12'd0, fv_q};
	assign lba_addr = (lba_sum > ADDR_MAX + ADDR_BIAS) ? ADDR_MAX : (lba_sum - ADDR_BIAS);

	always_comb begin
		f_inc = bcd_fix(frm_q + 8'd1);
		f_adv = f_inc;
		s_mid = sec_q;
		if (f_inc == 8'h75) begin
			s_mid = sec_q + 8'd1;
			f_adv = 8'd0;
		end
		s_adv = bcd_fix(s_mid);
		m_mid = min_q;
		if (s_adv == 8'h60) begin
			m_mid = min_q + 8'd1;
			s_adv = 8'd0;
		end
		m_adv = bcd_fix(m_mid);
	end

	assign pread_byte = {1'b0, off_ok, rsp_cnt_q != '0, !prm_full, prm_empty, 1'b0, bank_q};

	always_comb begin
		app_en = 1'b0;
		app_kind = K_BYTE;
		app_val = 32'd0;
		app_irq = 2'd0;
		err_set = cmd.err | (cmd.pop & prm_empty);
		prm_push = 1'b0;
		rsp_pop = 1'b0;
		rsp_push = cmd.push & !rsp_full;
		case (cmd.act)
			ACT_PREAD: begin
				app_en = 1'b1;
				case (port_q)
					PORT_INDEX: app_val = {24'd0, pread_byte};
					PORT_ONE: begin
						if (rsp_cnt_q == '0) begin
							err_set = 1'b1;
						end else begin
							app_val = {24'd0, rsp_head_q};
							rsp_pop = 1'b1;
						end
					end
					PORT_THREE: begin
						if (bank_q == BANK_ZERO) begin
							app_val = {27'd0, ien_q};
						end else if (bank_q == BANK_ONE) begin
							app_val = {27'd0, iflg_q};
						end else begin
							err_set = 1'b1;
						end
					end
					default: err_set = 1'b1;
				endcase
			end
			ACT_PWRITE: begin
				case (port_q)
					PORT_INDEX: ;
					PORT_ONE: err_set = (bank_q == BANK_ONE || bank_q == BANK_TWO);
					PORT_TWO: prm_push = (bank_q == BANK_ZERO) && !prm_full;
					PORT_THREE: ;
					default: err_set = 1'b1;
				endcase
			end
			ACT_DELIVER: begin
				if ((ien_q & flg_new) != 5'd0) begin
					app_en = 1'b1;
					app_kind = K_INT;
				end
			end
			ACT_SECTOR: begin
				app_en = 1'b1;
				app_kind = K_SECTOR;
				app_val = {12'd0, lba_addr};
			end
			ACT_DREAD: begin
				app_en = 1'b1;
				app_kind = K_WORD;
				if (off_ok) begin
					app_val = sec_rdata_q;
				end else begin
					err_set = 1'b1;
				end
			end
			ACT_LONE: app_en = err_q && (res_cnt_q == 2'd0);
			default: ;
		endcase
		if (cmd.sched) begin
			app_en = 1'b1;
			app_kind = K_SCHED;
			app_val = {10'd0, cmd.sdelay};
			app_irq = cmd.sirq;
		end
		if (cmd.cancel) begin
			app_en = 1'b1;
			app_kind = K_CANCEL;
		end
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 2'd0;
			mode_q <= 8'd0;
			status_q <= 8'd0;
			ien_q <= 5'd0;
			iflg_q <= 5'd0;
			min_q <= 8'd0;
			sec_q <= 8'd0;
			frm_q <= 8'd0;
			offset_q <= 12'd0;
			prm_rd_q <= '0;
			prm_wr_q <= '0;
			prm_cnt_q <= '0;
			rsp_rd_q <= '0;
			rsp_wr_q <= '0;
			rsp_cnt_q <= '0;
			res_cnt_q <= 2'd0;
			res_idx_q <= 2'd0;
			err_q <= 1'b0;
		end else begin
			if (cmd.act == ACT_LATCH) begin
				res_cnt_q <= 2'd0;
				res_idx_q <= 2'd0;
				err_q <= 1'b0;
			end else begin
				if (err_set) begin
					err_q <= 1'b1;
				end
				if (app_en && res_cnt_q != 2'd3) begin
					res_cnt_q <= res_cnt_q + 2'd1;
				end
				if (cmd.out_adv) begin
					res_idx_q <= res_idx_q + 2'd1;
				end
			end
			if (cmd.act == ACT_PWRITE) begin
				if (port_q == PORT_INDEX) begin
					bank_q <= wbyte_q[1:0];
				end
				if (port_q == PORT_TWO && bank_q == BANK_ONE) begin
					ien_q <= wbyte_q[4:0];
				end
				if (port_q == PORT_THREE && bank_q == BANK_ONE) begin
					iflg_q <= iflg_q & ~wbyte_q[4:0];
				end
			end
			if (cmd.act == ACT_DELIVER) begin
				iflg_q <= flg_new;
			end
			case (cmd.st_op)
				SO_CLR_SHELL: status_q <= status_q & ~8'h10;
				SO_READ: status_q <= (status_q & ~8'h40) | 8'h20;
				SO_STOP: status_q <= status_q & ~8'hA0;
				SO_MOTOR: status_q <= status_q | 8'h02;
				SO_SEEK: status_q <= status_q | 8'h40;
				SO_MOTOR_READ: status_q <= status_q | 8'h22;
				default: ;
			endcase
			if (cmd.mode_init) begin
				mode_q <= 8'h20;
			end
			if (cmd.pop) begin
				case (cmd.pdst)
					PD_MIN: min_q <= pop_val;
					PD_SEC: sec_q <= pop_val;
					PD_FRM: frm_q <= pop_val;
					PD_MODE: mode_q <= pop_val;
					default: ;
				endcase
				if (!prm_empty) begin
					prm_rd_q <= (prm_rd_q == PPW'(PARAM_DEPTH - 1)) ? '0 : prm_rd_q + 1'b1;
					prm_cnt_q <= prm_cnt_q - 1'b1;
				end
			end
			if (prm_push) begin
				prm_wr_q <= (prm_wr_q == PPW'(PARAM_DEPTH - 1)) ? '0 : prm_wr_q + 1'b1;
				prm_cnt_q <= prm_cnt_q + 1'b1;
			end
			if (cmd.resp_clear) begin
				rsp_wr_q <= rsp_rd_q;
				rsp_cnt_q <= '0;
			end
			if (rsp_push) begin
				rsp_wr_q <= (rsp_wr_q == RPW'(RESPONSE_DEPTH - 1)) ? '0 : rsp_wr_q + 1'b1;
				rsp_cnt_q <= rsp_cnt_q + 1'b1;
			end
			if (rsp_pop) begin
				rsp_rd_q <= (rsp_rd_q == RPW'(RESPONSE_DEPTH - 1)) ? '0 : rsp_rd_q + 1'b1;
				rsp_cnt_q <= rsp_cnt_q - 1'b1;
			end
			if (cmd.act == ACT_SECTOR) begin
				offset_q <= mode_q[5] ? OFS_FULL : OFS_DATA;
				frm_q <= f_adv;
				sec_q <= s_adv;
				min_q <= m_adv;
			end
			if (cmd.act == ACT_DREAD && off_ok) begin
				offset_q <= offset_q + 12'd4;
			end
		end
	end

	// Payload registers and memories.
	always_ff @(posedge clk) begin
		if (cmd.act == ACT_LATCH) begin
			op_q <= operation;
			port_q <= port;
			wbyte_q <= write_byte;
			irq_q <= event_irq;
			lword_q <= load_word;
			lidx_q <= load_index;
		end
		if (app_en && res_cnt_q != 2'd3 && cmd.act != ACT_LATCH) begin
			res_kind_q[res_cnt_q] <= app_kind;
			res_val_q[res_cnt_q] <= app_val;
			res_irq_q[res_cnt_q] <= app_irq;
		end
		if (cmd.act == ACT_PREP) begin
			mv_q <= bcd_val(min_q);
			sv_q <= bcd_val(sec_q);
			fv_q <= bcd_val(frm_q);
		end
	end

	always_ff @(posedge clk) begin
		if (prm_push) begin
			prm_mem[prm_wr_q] <= wbyte_q;
		end
		prm_head_q <= prm_mem[prm_rd_q];
	end

	always_ff @(posedge clk) begin
		if (rsp_push) begin
			rsp_mem[rsp_wr_q] <= push_val;
		end
		rsp_head_q <= rsp_mem[rsp_rd_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.act == ACT_LOAD && lidx_q < 10'(SECTOR_WORDS)) begin
			sec_mem[lidx_q] <= lword_q;
		end
		sec_rdata_q <= sec_mem[sec_raddr];
	end

	always_comb begin
		stat.op = op_q;
		stat.port = port_q;
		stat.wbyte = wbyte_q;
		stat.irq = irq_q;
		stat.bank = bank_q;
		stat.prm_empty = prm_empty;
		stat.prm_head = prm_head_q;
		stat.speed = mode_q[7];
		stat.play_read = (status_q & 8'hA0) != 8'd0;
		stat.res_cnt = res_cnt_q;
		stat.err = err_q;
		stat.out_last = (res_idx_q == res_cnt_q - 2'd1);
	end

	kind_t out_kind;
	logic [31:0] out_val;
	assign out_kind = res_kind_q[res_idx_q];
	assign out_val = res_val_q[res_idx_q];
	assign kind = out_kind;
	assign read_byte = (out_kind == K_BYTE) ? out_val[7:0] : 8'd0;
	assign data_word = (out_kind == K_WORD) ? out_val : 32'd0;
	assign sched_irq = (out_kind == K_SCHED) ? res_irq_q[res_idx_q] : 2'd0;
	assign sched_delay = (out_kind == K_SCHED) ? out_val[21:0] : 22'd0;
	assign sector_address = (out_kind == K_SECTOR) ? $signed(out_val[19:0]) : 20'sd0;
	assign last = stat.out_last;
	assign error = err_q;

`ifndef ASSERT_OFF
	a_prm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		prm_cnt_q <= PCW'(PARAM_DEPTH))
		else $error("parameter FIFO count exceeds its depth");
	a_rsp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_cnt_q <= RCW'(RESPONSE_DEPTH))
		else $error("response FIFO count exceeds its depth");
	a_ofs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		offset_q <= DATA_END + 12'd3)
		else $error("data offset advanced past the end of the sector");
`endif

endmodule

// File: bench/cdhi_checker.sv
// Transaction checker: predicts the disc controller's results and compares them.
`timescale 1ns / 1ps

module cdhi_checker import cdhi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         operation,
	input  logic [2:0]         port,
	input  logic [7:0]         write_byte,
	input  logic [1:0]         event_irq,
	input  logic [31:0]        load_word,
	input  logic [9:0]         load_index,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [2:0]         kind,
	input  logic [7:0]         read_byte,
	input  logic [31:0]        data_word,
	input  logic [1:0]         sched_irq,
	input  logic [21:0]        sched_delay,
	input  logic signed [19:0] sector_address,
	input  logic               last,
	input  logic               error,
	output int                 fail_count,
	output int                 pending,
	output logic               word_ready,
	output logic [9:0]         word_needed,
	output logic               past_end
);

	localparam int FIFO_DEPTH = 16;
	localparam int WORDS = 588;
	localparam logic [11:0] END_OFS = 12'h818;
	localparam logic [7:0] S_MOTOR = 8'h02;
	localparam logic [7:0] S_SHELL = 8'h10;
	localparam logic [7:0] S_READ = 8'h20;
	localparam logic [7:0] S_SEEK = 8'h40;
	localparam logic [7:0] S_PLAY = 8'h80;
	localparam logic [21:0] T_ACK = 22'd10000;
	localparam logic [21:0] T_ONE = 22'd451584;
	localparam logic [21:0] T_TWO = 22'd225792;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  rbyte;
		logic [31:0] dword;
		logic [1:0]  irq;
		logic [21:0] delay;
		logic [19:0] addr;
		logic        fin;
		logic        err;
	} drive_result_t;

	drive_result_t result_q[$];
	drive_result_t batch[3];
	int nres;
	bit step_err;

	logic [1:0] bank;
	logic [7:0] mode, status, min_bcd, sec_bcd, frm_bcd;
	logic [4:0] ien, iflags;
	logic [7:0] params[$];
	logic [7:0] replies[$];
	logic [31:0] sectors[WORDS];
	bit loaded[WORDS];
	logic [11:0] ofs;

	function automatic void add_result(logic [2:0] k, logic [7:0] b, logic [31:0] w,
			logic [1:0] q, logic [21:0] d, logic [19:0] a);
		if (nres < 3) begin
			batch[nres] = '{k, b, w, q, d, a, 1'b0, 1'b0};
			nres++;
		end
	endfunction

	function automatic void schedule(logic [1:0] q, logic [21:0] d);
		add_result(K_SCHED, 8'd0, 32'd0, q, d, 20'd0);
	endfunction

	function automatic void reply(logic [7:0] b);
		if (replies.size() < FIFO_DEPTH) replies.push_back(b);
	endfunction

	function automatic logic [7:0] take_param();
		if (params.size() == 0) begin
			step_err = 1'b1;
			return 8'd0;
		end
		return params.pop_front();
	endfunction

	function automatic int digits(logic [7:0] b);
		return int'(b[7:4]) * 10 + int'(b[3:0]);
	endfunction

	// A low digit of ten carries into the high digit.
	function automatic logic [7:0] carry_fix(logic [7:0] v);
		if (v[3:0] == 4'd10) return (v + 8'h10) & 8'hF0;
		return v;
	endfunction

	function automatic void next_sector();
		int a;
		a = digits(min_bcd) * 4500 + digits(sec_bcd) * 75 + digits(frm_bcd) - 150;
		if (a > 449849) a = 449849;
		add_result(K_SECTOR, 8'd0, 32'd0, 2'd0, 22'd0, a[19:0]);
		ofs = mode[5] ? 12'h00C : 12'h018;
		frm_bcd = carry_fix(frm_bcd + 8'd1);
		if (frm_bcd == 8'h75) begin
			sec_bcd++;
			frm_bcd = 8'h00;
		end
		sec_bcd = carry_fix(sec_bcd);
		if (sec_bcd == 8'h60) begin
			min_bcd++;
			sec_bcd = 8'h00;
		end
		min_bcd = carry_fix(min_bcd);
	endfunction

	function automatic void run_command(logic [7:0] c);
		logic [7:0] ident[8];
		logic [7:0] date[4];
		ident = '{8'h02, 8'h00, 8'h20, 8'h00, 8'h4D, 8'h41, 8'h52, 8'h49};
		date = '{8'h96, 8'h09, 8'h12, 8'hC2};
		case (c)
			CMD_GETSTAT: begin
				reply(status);
				status &= ~S_SHELL;
				schedule(IRQ_THREE, T_ACK);
			end
			CMD_SETLOC: begin
				reply(status);
				min_bcd = take_param();
				sec_bcd = take_param();
				frm_bcd = take_param();
				schedule(IRQ_THREE, T_ACK);
			end
			CMD_READN: begin
				reply(status);
				schedule(IRQ_THREE, T_ACK);
				status = (status & ~S_SEEK) | S_READ;
				schedule(IRQ_ONE, T_ACK + (mode[7] ? T_TWO : T_ONE));
			end
			CMD_PAUSE: begin
				add_result(K_CANCEL, 8'd0, 32'd0, 2'd0, 22'd0, 20'd0);
				replies.delete();
				reply(status);
				schedule(IRQ_THREE, T_ACK);
				if ((status & (S_PLAY | S_READ)) == 8'd0) schedule(IRQ_TWO, T_ACK + 22'd10000);
				else schedule(IRQ_TWO, T_ACK + 22'd5 * T_ONE);
				status &= ~(S_PLAY | S_READ);
				reply(status);
			end
			CMD_INIT: begin
				reply(mode);
				schedule(IRQ_THREE, 22'd80000);
				status |= S_MOTOR;
				mode = 8'h20;
				reply(mode);
				schedule(IRQ_TWO, 22'd100000);
			end
			CMD_DEMUTE: begin
				reply(status);
				schedule(IRQ_THREE, T_ACK);
			end
			CMD_SETMODE: begin
				reply(status);
				mode = take_param();
				schedule(IRQ_THREE, T_ACK);
			end
			CMD_GETTN: begin
				reply(status);
				reply(8'd1);
				reply(8'd1);
				schedule(IRQ_THREE, T_ACK);
			end
			CMD_GETTD: begin
				void'(take_param());
				reply(status);
				reply(8'd0);
				reply(8'd0);
				schedule(IRQ_THREE, T_ACK);
			end
			CMD_SEEKL: begin
				reply(status);
				schedule(IRQ_THREE, T_ACK);
				status |= S_SEEK;
				reply(status);
				schedule(IRQ_TWO, T_ACK + 22'd80000);
			end
			CMD_TEST: begin
				if (take_param() == TEST_DATE) begin
					foreach (date[i]) reply(date[i]);
					schedule(IRQ_THREE, T_ACK);
				end else begin
					step_err = 1'b1;
				end
			end
			CMD_GETID: begin
				reply(status);
				schedule(IRQ_THREE, T_ACK);
				foreach (ident[i]) reply(ident[i]);
				schedule(IRQ_TWO, T_ACK + 22'd30000);
			end
			CMD_READTOC: begin
				reply(status);
				status |= S_MOTOR | S_READ;
				reply(status);
				schedule(IRQ_THREE, T_ACK);
				schedule(IRQ_TWO, T_ACK + 22'd20000);
			end
			default: step_err = 1'b1;
		endcase
	endfunction

	function automatic void port_read(logic [2:0] p);
		logic [7:0] b;
		b = 8'd0;
		if (p == PORT_INDEX) begin
			b = {6'd0, bank};
			if (params.size() == 0) b |= 8'h08;
			if (params.size() != FIFO_DEPTH) b |= 8'h10;
			if (replies.size() != 0) b |= 8'h20;
			if (ofs < END_OFS) b |= 8'h40;
		end else if (p == PORT_ONE) begin
			if (replies.size() == 0) step_err = 1'b1;
			else b = replies.pop_front();
		end else if (p == PORT_THREE && bank == BANK_ZERO) begin
			b = {3'd0, ien};
		end else if (p == PORT_THREE && bank == BANK_ONE) begin
			b = {3'd0, iflags};
		end else begin
			step_err = 1'b1;
		end
		add_result(K_BYTE, b, 32'd0, 2'd0, 22'd0, 20'd0);
	endfunction

	function automatic void port_write(logic [2:0] p, logic [7:0] v);
		case (p)
			PORT_INDEX: bank = v[1:0];
			PORT_ONE: begin
				if (bank == BANK_ZERO) run_command(v);
				else if (bank != 2'd3) step_err = 1'b1;
			end
			PORT_TWO: begin
				if (bank == BANK_ZERO) begin
					if (params.size() < FIFO_DEPTH) params.push_back(v);
				end else if (bank == BANK_ONE) begin
					ien = v[4:0];
				end
			end
			PORT_THREE: if (bank == BANK_ONE) iflags &= ~v[4:0];
			default: step_err = 1'b1;
		endcase
	endfunction

	function automatic void predict(logic [2:0] op, logic [2:0] p, logic [7:0] wb,
			logic [1:0] q, logic [31:0] lw, logic [9:0] li);
		nres = 0;
		step_err = 1'b0;
		case (op)
			OP_PREAD: port_read(p);
			OP_PWRITE: port_write(p, wb);
			OP_EVENT: begin
				iflags |= {3'd0, q};
				if ((ien & iflags) != 5'd0) add_result(K_INT, 8'd0, 32'd0, 2'd0, 22'd0, 20'd0);
				if (q == IRQ_ONE) begin
					reply(status);
					next_sector();
					schedule(IRQ_ONE, mode[7] ? T_TWO : T_ONE);
				end
			end
			OP_LOAD: begin
				if (li < WORDS) begin
					sectors[li] = lw;
					loaded[li] = 1'b1;
				end
			end
			OP_DREAD: begin
				if (ofs < END_OFS) begin
					add_result(K_WORD, 8'd0, sectors[(ofs >> 2) % WORDS], 2'd0, 22'd0, 20'd0);
					ofs += 12'd4;
				end else begin
					step_err = 1'b1;
					add_result(K_WORD, 8'd0, 32'd0, 2'd0, 22'd0, 20'd0);
				end
			end
			default: ;
		endcase
		if (step_err && nres == 0) add_result(K_BYTE, 8'd0, 32'd0, 2'd0, 22'd0, 20'd0);
		for (int i = 0; i < nres; i++) begin
			batch[i].err = step_err;
			batch[i].fin = (i == nres - 1);
			result_q.push_back(batch[i]);
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_result_t w;
		if (!arst_n) begin
			bank = 2'd0;
			mode = 8'd0;
			status = 8'd0;
			ien = 5'd0;
			iflags = 5'd0;
			params.delete();
			replies.delete();
			min_bcd = 8'd0;
			sec_bcd = 8'd0;
			frm_bcd = 8'd0;
			ofs = 12'd0;
			foreach (loaded[i]) loaded[i] = 1'b0;
			result_q.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual kind %0h",
						$realtime, kind);
					fail_count++;
				end else begin
					w = result_q.pop_front();
					check_field("kind", w.kind, kind);
					check_field("read_byte", w.rbyte, read_byte);
					check_field("data_word", w.dword, data_word);
					check_field("sched_irq", w.irq, sched_irq);
					check_field("sched_delay", w.delay, sched_delay);
					check_field("sector_address", w.addr, $unsigned(sector_address));
					check_field("last", w.fin, last);
					check_field("error", w.err, error);
				end
			end
			if (in_valid && in_ready)
				predict(operation, port, write_byte, event_irq, load_word, load_index);
		end
		pending = result_q.size();
		word_needed = 10'((ofs >> 2) % WORDS);
		past_end = (ofs >= END_OFS);
		word_ready = past_end || loaded[word_needed];
	end

endmodule

// File: bench/tb_top.sv
// Top of the disc controller bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top import cdhi_pkg::*;;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] operation = '0;
	logic [2:0] port = '0;
	logic [7:0] write_byte = '0;
	logic [1:0] event_irq = '0;
	logic [31:0] load_word = '0;
	logic [9:0] load_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] kind;
	logic [7:0] read_byte;
	logic [31:0] data_word;
	logic [1:0] sched_irq;
	logic [21:0] sched_delay;
	logic signed [19:0] sector_address;
	logic last, error;
	int fail_count, pending;
	logic word_ready, past_end;
	logic [9:0] word_needed;
	int ready_hold = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cdrom_controller_host_interface_unit dut (.*);
	cdhi_checker u_checker (.*);

	// Receiver stalls: mostly short, now and then long, with ready stretches between.
	always @(posedge clk) begin
		int r;
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				out_ready <= 1'b1;
				ready_hold <= $urandom_range(0, 4);
			end else if (r < 60) begin
				out_ready <= 1'b1;
				ready_hold <= $urandom_range(40, 200);
			end else if (r < 92) begin
				out_ready <= 1'b0;
				ready_hold <= $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b0;
				ready_hold <= $urandom_range(10, 50);
			end
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// The trailing wait after the handshake lets the checker settle before the next decision.
	task automatic send(input logic [2:0] op, input logic [2:0] p, input logic [7:0] wb,
			input logic [1:0] q, input logic [31:0] lw, input logic [9:0] li);
		repeat (gap_len()) @(posedge clk);
		in_valid <= 1'b1;
		operation <= op;
		port <= p;
		write_byte <= wb;
		event_irq <= q;
		load_word <= lw;
		load_index <= li;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wr(input logic [2:0] p, input logic [7:0] b);
		send(OP_PWRITE, p, b, 2'($urandom), $urandom, 10'($urandom));
	endtask

	task automatic rd(input logic [2:0] p);
		send(OP_PREAD, p, 8'($urandom), 2'($urandom), $urandom, 10'($urandom));
	endtask

	task automatic fire(input logic [1:0] q);
		send(OP_EVENT, 3'($urandom), 8'($urandom), q, $urandom, 10'($urandom));
	endtask

	task automatic load(input logic [9:0] idx);
		send(OP_LOAD, 3'($urandom), 8'($urandom), 2'($urandom), $urandom, idx);
	endtask

	// Never read a sector word that has not been loaded.
	task automatic word_read();
		if (!word_ready) load(word_needed);
		send(OP_DREAD, 3'($urandom), 8'($urandom), 2'($urandom), $urandom, 10'($urandom));
	endtask

	task automatic idle_wait();
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [7:0] bcd_byte();
		return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
	endfunction

	task automatic command_seq();
		logic [7:0] cmds[13];
		logic [7:0] v;
		int n, r;
		cmds = '{CMD_GETSTAT, CMD_SETLOC, CMD_READN, CMD_PAUSE, CMD_INIT, CMD_DEMUTE,
			CMD_SETMODE, CMD_GETTN, CMD_GETTD, CMD_SEEKL, CMD_TEST, CMD_GETID, CMD_READTOC};
		wr(PORT_INDEX, {6'($urandom), BANK_ZERO});
		n = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			if (r < 5) v = bcd_byte();
			else if (r < 7) v = TEST_DATE;
			else if (r < 8) v = {$urandom_range(0, 1) ? 8'h80 : 8'h00} | 8'h20;
			else v = 8'($urandom);
			wr(PORT_TWO, v);
		end
		if ($urandom_range(0, 9) == 0) v = 8'($urandom);
		else v = cmds[$urandom_range(0, 12)];
		wr(PORT_ONE, v);
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) rd(PORT_ONE);
	endtask

	initial begin
		int r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		rd(PORT_INDEX);
		rd(PORT_ONE);
		wr(PORT_INDEX, 8'hFD);
		wr(PORT_TWO, 8'hFF);
		fire(2'd0);
		rd(PORT_THREE);
		wr(PORT_ONE, 8'h00);
		wr(PORT_INDEX, BANK_TWO);
		rd(PORT_THREE);
		wr(PORT_ONE, 8'hFF);
		wr(3'd7, 8'h00);
		wr(3'd4, 8'hA5);
		rd(PORT_TWO);
		rd(3'd5);
		send(3'd7, 3'd0, 8'd0, 2'd0, 32'hFFFF_FFFF, 10'd0);
		load(10'd1023);
		load(10'd587);
		word_read();
		wr(PORT_INDEX, BANK_ZERO);
		wr(PORT_ONE, CMD_INIT);
		wr(PORT_ONE, CMD_GETID);
		wr(PORT_ONE, CMD_GETID);
		wr(PORT_ONE, 8'h00);
		wr(PORT_ONE, CMD_TEST);
		fire(IRQ_ONE);
		idle_wait();

		// Random part.
		for (int i = 0; i < 100; i++) begin
			if (i == 50) idle_wait();
			r = $urandom_range(0, 99);
			if (r < 30) command_seq();
			else if (r < 42) rd(PORT_ONE);
			else if (r < 50) begin
				wr(PORT_INDEX, {6'($urandom), BANK_ONE});
				if ($urandom_range(0, 1)) wr(PORT_TWO, 8'($urandom));
				else wr(PORT_THREE, 8'($urandom));
				rd(PORT_THREE);
			end else if (r < 60) fire($urandom_range(0, 9) == 0 ? 2'd0 : 2'($urandom_range(1, 3)));
			else if (r < 68) rd(3'($urandom));
			else if (r < 80) word_read();
			else if (r < 90) load(10'($urandom));
			else send(3'($urandom_range(0, 7)), 3'($urandom), 8'($urandom), 2'($urandom),
				$urandom, 10'($urandom));
		end

		r = 0;
		while (pending != 0 && r < 200000) begin
			@(posedge clk);
			r++;
		end
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
